FILE: design/cbt_pkg.sv
// Package: shared types, codes and helpers for the circuit breaker table.
`timescale 1ns / 1ps
package cbt_pkg;

	localparam int CBT_NUM_CIRCUITS = 16;
	localparam int CBT_IDX_W        = 4;

	typedef enum logic [2:0] {
		CMD_REGISTER = 3'd0,
		CMD_QUERY    = 3'd1,
		CMD_SUCCESS  = 3'd2,
		CMD_FAILURE  = 3'd3,
		CMD_STATS    = 3'd4
	} cbt_cmd_t;

	typedef enum logic [1:0] {
		BRK_CLOSED = 2'd0,
		BRK_OPEN   = 2'd1,
		BRK_HALF   = 2'd2
	} breaker_t;

	typedef enum logic [1:0] {
		TR_NONE   = 2'd0,
		TR_OPENED = 2'd1,
		TR_HALF   = 2'd2,
		TR_CLOSED = 2'd3
	} trans_t;

	typedef enum logic [1:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_EXEC
	} ctl_state_t;

	// One table entry as it is kept in the RAM.
	typedef struct packed {
		logic        valid;
		breaker_t    state;
		logic [15:0] fail_thr;
		logic [15:0] succ_thr;
		logic [31:0] timeout;
		logic [15:0] fail_run;
		logic [15:0] succ_run;
		logic [31:0] last_fail;
		logic [31:0] req_cnt;
		logic [31:0] succ_cnt;
		logic [31:0] fail_cnt;
	} cbt_rec_t;

	// One result item.
	typedef struct packed {
		logic        allowed;
		breaker_t    state;
		logic        registered;
		trans_t      trans;
		logic [31:0] req_cnt;
		logic [31:0] succ_cnt;
		logic [31:0] fail_cnt;
	} cbt_res_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == '1) ? v : v + 16'd1;
	endfunction

endpackage

FILE: design/cbt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module cbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/cbt_update.sv
// Entry update: computes the new table entry and the result item for one command.
`timescale 1ns / 1ps
module cbt_update (
	input  logic [2:0]       cmd,
	input  logic             present,
	input  logic [31:0]      now_ms,
	input  logic [15:0]      failure_threshold,
	input  logic [15:0]      success_threshold,
	input  logic [31:0]      timeout_ms,
	input  cbt_pkg::cbt_rec_t rec_in,
	output cbt_pkg::cbt_rec_t rec_out,
	output logic             wr_en,
	output cbt_pkg::cbt_res_t res
);
	import cbt_pkg::*;

	logic        open_expired;
	logic [15:0] succ_run_inc;
	logic [15:0] fail_run_inc;
	trans_t      trans;
	logic        allowed;

	assign open_expired = (now_ms - rec_in.last_fail) >= rec_in.timeout;
	assign succ_run_inc = sat_inc16(rec_in.succ_run);
	assign fail_run_inc = sat_inc16(rec_in.fail_run);

	always_comb begin
		rec_out = rec_in;
		wr_en   = 1'b0;
		trans   = TR_NONE;
		allowed = 1'b0;
		res     = '0;

		if (!present) begin
			res.allowed = (cmd == CMD_QUERY);
		end else if (cmd == CMD_REGISTER) begin
			rec_out          = '0;
			rec_out.valid    = 1'b1;
			rec_out.state    = BRK_CLOSED;
			rec_out.fail_thr = failure_threshold;
			rec_out.succ_thr = success_threshold;
			rec_out.timeout  = timeout_ms;
			wr_en            = 1'b1;
		end else if (!rec_in.valid) begin
			res.allowed = (cmd == CMD_QUERY);
		end else begin
			wr_en = 1'b1;
			case (cmd)
				CMD_QUERY: begin
					if (rec_in.state == BRK_OPEN) begin
						if (open_expired) begin
							rec_out.state = BRK_HALF;
							trans         = TR_HALF;
							allowed       = 1'b1;
						end
					end else begin
						allowed = 1'b1;
					end
					if (allowed) begin
						rec_out.req_cnt = sat_inc32(rec_in.req_cnt);
					end
				end
				CMD_SUCCESS: begin
					rec_out.succ_cnt = sat_inc32(rec_in.succ_cnt);
					rec_out.fail_run = '0;
					if (rec_in.state == BRK_HALF) begin
						if (succ_run_inc >= rec_in.succ_thr) begin
							rec_out.state    = BRK_CLOSED;
							rec_out.succ_run = '0;
							trans            = TR_CLOSED;
						end else begin
							rec_out.succ_run = succ_run_inc;
						end
					end
				end
				CMD_FAILURE: begin
					rec_out.fail_cnt  = sat_inc32(rec_in.fail_cnt);
					rec_out.last_fail = now_ms;
					if (rec_in.state == BRK_CLOSED) begin
						rec_out.fail_run = fail_run_inc;
						if (fail_run_inc >= rec_in.fail_thr) begin
							rec_out.state    = BRK_OPEN;
							rec_out.succ_run = '0;
							trans            = TR_OPENED;
						end
					end else if (rec_in.state == BRK_HALF) begin
						rec_out.state    = BRK_OPEN;
						rec_out.succ_run = '0;
						trans            = TR_OPENED;
					end
				end
				default: begin
					// Read stats and the unused codes leave the entry as it is.
				end
			endcase
		end

		if (wr_en) begin
			res.allowed    = allowed;
			res.state      = rec_out.state;
			res.registered = 1'b1;
			res.trans      = trans;
			res.req_cnt    = rec_out.req_cnt;
			res.succ_cnt   = rec_out.succ_cnt;
			res.fail_cnt   = rec_out.fail_cnt;
		end
	end

endmodule

FILE: design/circuit_breaker_table.sv
// Top level: circuit breaker table with one RAM-held record per circuit.
`timescale 1ns / 1ps
// How to use this block:
// The command channel takes one item at a rising clock edge where start is
// high and busy is low. An item carries cmd, circuit_index, now_ms and, for a
// register command, the two thresholds and the timeout.
// Every item produces exactly one result item. The result ports hold it for
// one clock cycle with done high; the receiver cannot stall, so it must take
// the item in that cycle.
// An item accepted at a clock edge reads its table record from the RAM on
// that edge, the update logic works on the record during the next cycle, and
// at the end of that cycle the new record is written back and the result
// registers load. done is high in the cycle after that, and busy is low again
// in that same cycle; until then busy stays high and no new item is taken.
// Each item is a single RAM read-modify-write; since the write of one item
// lands before the read of the next, no forwarding is needed.
// Reset: after arst_n is released, the block walks the RAM and marks every
// record unregistered, one record per cycle. busy is high during this pass
// and no item is accepted.
// An index at or beyond NUM_CIRCUITS answers as an unregistered circuit.
module circuit_breaker_table #(
	parameter int NUM_CIRCUITS = cbt_pkg::CBT_NUM_CIRCUITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  circuit_index,
	input  logic [31:0] now_ms,
	input  logic [15:0] failure_threshold,
	input  logic [15:0] success_threshold,
	input  logic [31:0] timeout_ms,
	output logic        done,
	output logic        allowed,
	output logic [1:0]  breaker_state,
	output logic        is_registered,
	output logic [1:0]  transition,
	output logic [31:0] total_requests,
	output logic [31:0] successful_requests,
	output logic [31:0] failed_requests
);
	import cbt_pkg::*;

	localparam int AW = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;
	localparam int RW = $bits(cbt_rec_t);

	ctl_state_t state_q, state_d;

	// Clearing pass address.
	logic [AW-1:0] clr_q;

	// Item fields held while the record is read and updated.
	logic [2:0]  cmd_q;
	logic [3:0]  idx_q;
	logic        present_q;
	logic [31:0] now_q;
	logic [15:0] fth_q;
	logic [15:0] sth_q;
	logic [31:0] tmo_q;

	logic     accept;
	logic     ram_we;
	logic [AW-1:0] ram_waddr;
	cbt_rec_t ram_wdata;
	cbt_rec_t ram_rdata;
	cbt_rec_t upd_rec;
	logic     upd_we;
	cbt_res_t upd_res;

	cbt_res_t res_q;
	logic     done_q;

	assign accept = start && (state_q == CTL_IDLE);
	assign busy   = (state_q != CTL_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == CTL_EXEC);
			if (state_q == CTL_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Item and result registers carry payload only and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			idx_q     <= circuit_index;
			present_q <= (32'(circuit_index) < NUM_CIRCUITS);
			now_q     <= now_ms;
			fth_q     <= failure_threshold;
			sth_q     <= success_threshold;
			tmo_q     <= timeout_ms;
		end
		if (state_q == CTL_EXEC) begin
			res_q <= upd_res;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = AW'(idx_q);
		ram_wdata = upd_rec;
		case (state_q)
			CTL_CLEAR: begin
				// Every record starts unregistered.
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(NUM_CIRCUITS - 1)) begin
					state_d = CTL_IDLE;
				end
			end
			CTL_IDLE: begin
				if (start) begin
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				ram_we  = upd_we;
				state_d = CTL_IDLE;
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	cbt_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_CIRCUITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(circuit_index)),
		.rdata (ram_rdata)
	);

	cbt_update u_update (
		.cmd               (cmd_q),
		.present           (present_q),
		.now_ms            (now_q),
		.failure_threshold (fth_q),
		.success_threshold (sth_q),
		.timeout_ms        (tmo_q),
		.rec_in            (ram_rdata),
		.rec_out           (upd_rec),
		.wr_en             (upd_we),
		.res               (upd_res)
	);

	assign done                = done_q;
	assign allowed             = res_q.allowed;
	assign breaker_state       = res_q.state;
	assign is_registered       = res_q.registered;
	assign transition          = res_q.trans;
	assign total_requests      = res_q.req_cnt;
	assign successful_requests = res_q.succ_cnt;
	assign failed_requests     = res_q.fail_cnt;

endmodule

FILE: design/cbt_checker.sv
// Port-level checker for the circuit breaker table, bound to the top level.
`timescale 1ns / 1ps
module cbt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        is_registered,
	input logic [1:0]  breaker_state,
	input logic [1:0]  transition,
	input logic [31:0] total_requests
);
	import cbt_pkg::*;

	// Each accepted item yields its result once its record has been updated.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result did not follow an accepted item");

	// The block turns busy right after taking an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// A result is shown only while the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// An unregistered circuit reports a closed breaker with no activity.
	a_unreg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_registered) |->
		(breaker_state == BRK_CLOSED && transition == TR_NONE && total_requests == 32'd0))
		else $error("unregistered circuit reported state");

	// An opening transition leaves the breaker open.
	a_opened: assert property (@(posedge clk) disable iff (!arst_n)
		(done && transition == TR_OPENED) |-> (breaker_state == BRK_OPEN))
		else $error("opened transition without open state");

endmodule

bind circuit_breaker_table cbt_checker u_cbt_checker (.*);

FILE: tb/testbench.sv
// Testbench for the circuit breaker table: random and directed commands checked against a predictor.
`timescale 1ns / 1ps
module testbench;
	import cbt_pkg::*;

	localparam int  ENTRIES      = CBT_NUM_CIRCUITS;
	localparam int  CYCLE_LIMIT  = 300000;
	localparam int  SETTLE       = 6;
	localparam int  RANDOM_ITEMS = 1225;

	// One command item, plus the sender's idle chance and a drain marker.
	// A drain marker makes the driver hold off until every result has arrived.
	typedef struct {
		logic [2:0]  op;
		logic [3:0]  idx;
		logic [31:0] now;
		logic [15:0] fth;
		logic [15:0] sth;
		logic [31:0] tmo;
		int unsigned idle_pct;
		bit          drain;
	} cmd_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  cmd = '0;
	logic [3:0]  circuit_index = '0;
	logic [31:0] now_ms = '0;
	logic [15:0] failure_threshold = '0;
	logic [15:0] success_threshold = '0;
	logic [31:0] timeout_ms = '0;
	logic        busy;
	logic        done;
	logic        allowed;
	logic [1:0]  breaker_state;
	logic        is_registered;
	logic [1:0]  transition;
	logic [31:0] total_requests;
	logic [31:0] successful_requests;
	logic [31:0] failed_requests;

	circuit_breaker_table i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.cmd                 (cmd),
		.circuit_index       (circuit_index),
		.now_ms              (now_ms),
		.failure_threshold   (failure_threshold),
		.success_threshold   (success_threshold),
		.timeout_ms          (timeout_ms),
		.done                (done),
		.allowed             (allowed),
		.breaker_state       (breaker_state),
		.is_registered       (is_registered),
		.transition          (transition),
		.total_requests      (total_requests),
		.successful_requests (successful_requests),
		.failed_requests     (failed_requests)
	);

	always #5 clk = ~clk;

	cmd_item_t   pending_cmds[$];
	cbt_res_t    awaited_results[$];
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	bit          draining = 1'b0;
	int unsigned settle_left = 0;
	int unsigned cur_idle = 6;

	// Shadow copy of the breaker table.
	bit          brk_valid[ENTRIES];
	breaker_t    brk_state[ENTRIES];
	logic [15:0] fail_limit[ENTRIES];
	logic [15:0] succ_limit[ENTRIES];
	logic [15:0] fail_streak[ENTRIES];
	logic [15:0] succ_streak[ENTRIES];
	logic [31:0] open_window[ENTRIES];
	logic [31:0] last_fail_ms[ENTRIES];
	logic [31:0] req_tally[ENTRIES];
	logic [31:0] succ_tally[ENTRIES];
	logic [31:0] fail_tally[ENTRIES];

	function automatic logic [31:0] bump32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Applies one command to the shadow table and returns the answer the
	// block must give for it.
	function automatic cbt_res_t breaker_outcome(input cmd_item_t it);
		cbt_res_t    res;
		int          e;
		logic [31:0] elapsed;
		res = '0;
		res.state = BRK_CLOSED;
		res.trans = TR_NONE;
		e = int'(it.idx);
		if (e < ENTRIES && it.op == CMD_REGISTER) begin
			brk_valid[e]    = 1'b1;
			brk_state[e]    = BRK_CLOSED;
			fail_limit[e]   = it.fth;
			succ_limit[e]   = it.sth;
			open_window[e]  = it.tmo;
			fail_streak[e]  = '0;
			succ_streak[e]  = '0;
			last_fail_ms[e] = '0;
			req_tally[e]    = '0;
			succ_tally[e]   = '0;
			fail_tally[e]   = '0;
		end
		// An unregistered circuit lets every query through and keeps nothing.
		if (!(e < ENTRIES && brk_valid[e])) begin
			res.allowed = (it.op == CMD_QUERY);
			return res;
		end
		case (it.op)
			CMD_QUERY: begin
				res.allowed = 1'b1;
				if (brk_state[e] == BRK_OPEN) begin
					elapsed = it.now - last_fail_ms[e];
					if (elapsed >= open_window[e]) begin
						brk_state[e] = BRK_HALF;
						res.trans = TR_HALF;
					end else begin
						res.allowed = 1'b0;
					end
				end
				if (res.allowed)
					req_tally[e] = bump32(req_tally[e]);
			end
			CMD_SUCCESS: begin
				succ_tally[e]  = bump32(succ_tally[e]);
				fail_streak[e] = '0;
				if (brk_state[e] == BRK_HALF) begin
					succ_streak[e] = bump16(succ_streak[e]);
					if (succ_streak[e] >= succ_limit[e]) begin
						brk_state[e]   = BRK_CLOSED;
						succ_streak[e] = '0;
						res.trans = TR_CLOSED;
					end
				end
			end
			CMD_FAILURE: begin
				fail_tally[e]   = bump32(fail_tally[e]);
				last_fail_ms[e] = it.now;
				if (brk_state[e] == BRK_CLOSED) begin
					fail_streak[e] = bump16(fail_streak[e]);
					if (fail_streak[e] >= fail_limit[e]) begin
						brk_state[e]   = BRK_OPEN;
						succ_streak[e] = '0;
						res.trans = TR_OPENED;
					end
				end else if (brk_state[e] == BRK_HALF) begin
					// Any failure during the trial period reopens at once.
					brk_state[e]   = BRK_OPEN;
					succ_streak[e] = '0;
					res.trans = TR_OPENED;
				end
			end
			default: begin
			end
		endcase
		res.registered = 1'b1;
		res.state      = brk_state[e];
		res.req_cnt    = req_tally[e];
		res.succ_cnt   = succ_tally[e];
		res.fail_cnt   = fail_tally[e];
		return res;
	endfunction

	// Driver. An item is taken at an edge where start is high and busy is low;
	// the expected answer is worked out at that same edge. The next start
	// value is computed once so start is assigned a single time per edge.
	always @(posedge clk) begin : drive_cmds
		bit        fire;
		bit        nxt_start;
		cmd_item_t it;
		if (arst_n) begin
			fire = start && !busy;
			if (fire) begin
				it.op  = cmd;
				it.idx = circuit_index;
				it.now = now_ms;
				it.fth = failure_threshold;
				it.sth = success_threshold;
				it.tmo = timeout_ms;
				awaited_results.push_back(breaker_outcome(it));
			end
			nxt_start = start && !fire;
			if (!nxt_start) begin
				if (draining) begin
					if (awaited_results.size() == 0) begin
						if (settle_left == 0)
							draining = 1'b0;
						else
							settle_left--;
					end
				end else if (pending_cmds.size() > 0) begin
					if (pending_cmds[0].drain) begin
						void'(pending_cmds.pop_front());
						draining = 1'b1;
						settle_left = SETTLE;
					end else if ($urandom_range(99) >= pending_cmds[0].idle_pct) begin
						it = pending_cmds.pop_front();
						cmd               <= it.op;
						circuit_index     <= it.idx;
						now_ms            <= it.now;
						failure_threshold <= it.fth;
						success_threshold <= it.sth;
						timeout_ms        <= it.tmo;
						nxt_start = 1'b1;
					end
				end
			end
			start <= nxt_start;
		end
	end

	// Monitor. Each done cycle carries one result, compared with the oldest
	// expectation.
	always @(posedge clk) begin : watch_results
		cbt_res_t want;
		bit       bad;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result at %0t: state %0d trans %0d", $realtime,
						breaker_state, transition);
			end else begin
				want = awaited_results.pop_front();
				bad = (allowed !== want.allowed) || (breaker_state !== want.state) ||
					(is_registered !== want.registered) || (transition !== want.trans) ||
					(total_requests !== want.req_cnt) ||
					(successful_requests !== want.succ_cnt) ||
					(failed_requests !== want.fail_cnt);
				if (bad) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch at %0t: allowed %0b/%0b state %0d/%0d reg %0b/%0b",
							$realtime, want.allowed, allowed, want.state, breaker_state,
							want.registered, is_registered);
						$display("  trans %0d/%0d req %0d/%0d succ %0d/%0d fail %0d/%0d",
							want.trans, transition, want.req_cnt, total_requests,
							want.succ_cnt, successful_requests, want.fail_cnt,
							failed_requests);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [2:0] op, input logic [3:0] idx,
		input logic [31:0] now, input logic [15:0] fth, input logic [15:0] sth,
		input logic [31:0] tmo);
		cmd_item_t it;
		it.op = op;
		it.idx = idx;
		it.now = now;
		it.fth = fth;
		it.sth = sth;
		it.tmo = tmo;
		it.idle_pct = cur_idle;
		it.drain = 1'b0;
		pending_cmds.push_back(it);
	endtask

	task automatic queue_drain();
		cmd_item_t it;
		it = '{default: '0};
		it.drain = 1'b1;
		pending_cmds.push_back(it);
	endtask

	// Thresholds lean small so that breakers trip and recover often, with
	// the zero and all-ones extremes mixed in.
	function automatic logic [15:0] pick_threshold();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(4, 1));
		else if (r < 80)
			return 16'd0;
		else if (r < 90)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] pick_timeout();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 32'($urandom_range(40));
		else if (r < 70)
			return 32'd0;
		else if (r < 80)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	initial begin : stimulus
		logic [31:0] clock_ms;
		logic [2:0]  op;
		logic [3:0]  idx;
		int unsigned r;
		for (int e = 0; e < ENTRIES; e++) begin
			brk_valid[e] = 1'b0;
			brk_state[e] = BRK_CLOSED;
			fail_limit[e] = '0;
			succ_limit[e] = '0;
			fail_streak[e] = '0;
			succ_streak[e] = '0;
			open_window[e] = '0;
			last_fail_ms[e] = '0;
			req_tally[e] = '0;
			succ_tally[e] = '0;
			fail_tally[e] = '0;
		end

		// Directed part. Every command but register on a circuit that was never registered.
		cur_idle = 6;
		queue_cmd(CMD_QUERY,   4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_SUCCESS, 4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_FAILURE, 4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_STATS,   4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
		queue_cmd(3'd7,        4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
		// Single failure trips, zero timeout half-opens at once, one success closes.
		queue_cmd(CMD_REGISTER, 4'd0, 32'hFFFF_FFFF, 16'd1, 16'd1, 32'd0);
		queue_cmd(CMD_QUERY,    4'd0, 32'd50, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_FAILURE,  4'd0, 32'd100, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_QUERY,    4'd0, 32'd100, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_SUCCESS,  4'd0, 32'd101, 16'd0, 16'd0, 32'd0);
		// Zero thresholds are met by any run; the longest timeout only passes
		// when the elapsed time wraps all the way round.
		queue_cmd(CMD_REGISTER, 4'd15, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
		queue_cmd(CMD_SUCCESS,  4'd15, 32'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_FAILURE,  4'd15, 32'd5, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_QUERY,    4'd15, 32'd6, 16'd0, 16'd0, 32'd0);
		// A failure while open counts and restarts the timeout.
		queue_cmd(CMD_FAILURE,  4'd15, 32'd20, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_QUERY,    4'd15, 32'd19, 16'd0, 16'd0, 32'd0);
		// A failure while half-open reopens the breaker.
		queue_cmd(CMD_FAILURE,  4'd15, 32'd30, 16'd0, 16'd0, 32'd0);
		// Registering an open breaker reloads it without a transition code.
		queue_cmd(CMD_REGISTER, 4'd15, 32'd31, 16'hFFFF, 16'hFFFF, 32'd1);
		queue_cmd(CMD_FAILURE,  4'd15, 32'd32, 16'd0, 16'd0, 32'd0);
		queue_cmd(3'd5,         4'd15, 32'd33, 16'd0, 16'd0, 32'd0);
		queue_cmd(3'd6,         4'd15, 32'd34, 16'd0, 16'd0, 32'd0);
		// Threshold of two, and a query denied before the timeout runs out.
		queue_cmd(CMD_REGISTER, 4'd2, 32'd0, 16'd2, 16'd2, 32'd10);
		queue_cmd(CMD_FAILURE,  4'd2, 32'd0, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_FAILURE,  4'd2, 32'd1, 16'd0, 16'd0, 32'd0);
		queue_cmd(CMD_QUERY,    4'd2, 32'd5, 16'd0, 16'd0, 32'd0);
		queue_drain();

		// Random part. Most commands land on a few busy circuits so that whole
		// trip, wait, trial and recovery sequences happen; time mostly creeps
		// forward, with occasional jumps to arbitrary values.
		clock_ms = $urandom;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400) begin
				queue_drain();
				cur_idle = 85;
			end else if (n == 800) begin
				queue_drain();
				cur_idle = 0;
			end
			if ($urandom_range(99) < 5)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + 32'($urandom_range(20));
			idx = ($urandom_range(99) < 70) ? 4'($urandom_range(5)) : 4'($urandom);
			r = $urandom_range(99);
			if (r < 8)
				op = CMD_REGISTER;
			else if (r < 43)
				op = CMD_QUERY;
			else if (r < 63)
				op = CMD_SUCCESS;
			else if (r < 88)
				op = CMD_FAILURE;
			else if (r < 94)
				op = CMD_STATS;
			else
				op = 3'($urandom_range(7, 5));
			if (op == CMD_REGISTER)
				queue_cmd(op, idx, clock_ms, pick_threshold(), pick_threshold(),
					pick_timeout());
			else
				queue_cmd(op, idx, clock_ms, 16'($urandom), 16'($urandom), $urandom);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || draining || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (awaited_results.size() != 0)
			fault_count++;
		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
